// File: rtl/smd_pkg.sv
// Shared types, constants and SHA-256 helper functions for the message digest block.
package smd_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } smd_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } smd_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } smd_state_type;

   typedef struct packed {
      logic push;
      logic advance;
   } smd_sched_ctl_type;

   typedef struct packed {
      logic load;
      logic step;
   } smd_round_ctl_type;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] BLOCK_LAST = 6'd63;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST  = 3'd7;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] iv_word(input logic [2:0] idx);
      case (idx)
         3'd0: iv_word = 32'h6a09e667;
         3'd1: iv_word = 32'hbb67ae85;
         3'd2: iv_word = 32'h3c6ef372;
         3'd3: iv_word = 32'ha54ff53a;
         3'd4: iv_word = 32'h510e527f;
         3'd5: iv_word = 32'h9b05688c;
         3'd6: iv_word = 32'h1f83d9ab;
         default: iv_word = 32'h5be0cd19;
      endcase
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      case (idx)
         6'd0:  round_k = 32'h428a2f98;
         6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;
         6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;
         6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;
         6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;
         6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;
         6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;
         6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;
         6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;
         6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;
         6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;
         6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;
         6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;
         6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;
         6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;
         6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;
         6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;
         6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;
         6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;
         6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;
         6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;
         6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;
         6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;
         6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;
         6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;
         6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;
         6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;
         6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;
         6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;
         6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;
         6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;
         6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;
         default: round_k = 32'hc67178f2;
      endcase
   endfunction

endpackage

// File: rtl/smd_sched.sv
// Message schedule: sixteen-word window that takes block words and extends the schedule.
module smd_sched (
   input  logic                      clock,
   input  smd_pkg::smd_sched_ctl_type ctl,
   input  logic [31:0]               push_word,
   output logic [31:0]               sched_word
);
   import smd_pkg::*;

   logic [15:0][31:0] win_ff;
   logic [15:0][31:0] win_in;
   logic [31:0]       next_word;

   assign next_word  = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
   assign sched_word = win_ff[0];

   always_comb begin
      win_in = win_ff;
      if (ctl.push || ctl.advance) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = ctl.push ? push_word : next_word;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// File: rtl/smd_round.sv
// Compression round unit: eight working words advanced one round per cycle.
module smd_round (
   input  logic                      clock,
   input  smd_pkg::smd_round_ctl_type ctl,
   input  logic [7:0][31:0]          hash_words,
   input  logic [31:0]               sched_word,
   input  logic [5:0]                round_idx,
   output logic [7:0][31:0]          work_words
);
   import smd_pkg::*;

   logic [7:0][31:0] v_ff;
   logic [7:0][31:0] v_in;
   logic [31:0]      choose;
   logic [31:0]      major;
   logic [31:0]      tmp1;
   logic [31:0]      tmp2;

   assign choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign tmp1   = v_ff[7] + big_sigma1(v_ff[4]) + choose + round_k(round_idx) + sched_word;
   assign tmp2   = big_sigma0(v_ff[0]) + major;
   assign work_words = v_ff;

   always_comb begin
      v_in = v_ff;
      if (ctl.load) begin
         v_in = hash_words;
      end else if (ctl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + tmp1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = tmp1 + tmp2;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

endmodule

// File: rtl/sha256_message_digest.sv
// Top level: byte intake, padding sequencer, hash state and digest output.
// Intake: each byte is taken in ST_IDLE; the 64th byte of a block starts the rounds, then the add.
// Close: padding bytes go in at 1 per cycle to the block end, each block is then compressed;
// a fill of 56 or more at close pads and compresses two blocks, then emits the digest words.
// Throughput: one byte per cycle at most, only in ST_IDLE; intake stalls in every other state.
// Reset: synchronous; hash words load the initial values, counters clear, block goes idle.
module sha256_message_digest (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  smd_pkg::smd_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output smd_pkg::smd_rsp_type rsp_data
);
   import smd_pkg::*;

   smd_state_type     state_ff, state_in;
   logic [5:0]        pos_ff, pos_in;
   logic [60:0]       count_ff, count_in;
   logic [60:0]       count_next;
   logic [23:0]       word_ff, word_in;
   logic [63:0]       len_ff, len_in;
   logic [5:0]        rnd_ff, rnd_in;
   logic [2:0]        out_idx_ff, out_idx_in;
   logic              closing_ff, closing_in;
   logic              mark_ff, mark_in;
   logic              len_ok_ff, len_ok_in;
   logic              final_ff, final_in;
   logic [7:0][31:0]  hash_ff, hash_in;
   logic [7:0][31:0]  work_words;
   logic [5:0]        pos_after;
   logic              absorb;
   logic [7:0]        absorb_byte;
   logic [31:0]       push_word;
   logic [31:0]       sched_word;
   smd_sched_ctl_type sched_ctl;
   smd_round_ctl_type round_ctl;

   assign count_next = count_ff + 61'd1;
   assign pos_after  = pos_ff + {5'd0, req_data.has_byte};
   assign push_word  = {word_ff, absorb_byte};

   smd_sched u_sched (
      .clock      (clock),
      .ctl        (sched_ctl),
      .push_word  (push_word),
      .sched_word (sched_word)
   );

   smd_round u_round (
      .clock      (clock),
      .ctl        (round_ctl),
      .hash_words (hash_ff),
      .sched_word (sched_word),
      .round_idx  (rnd_ff),
      .work_words (work_words)
   );

   always_comb begin
      rsp_data.digest_word = hash_ff[out_idx_ff];
      rsp_data.word_index  = out_idx_ff;
      rsp_data.last_word   = (out_idx_ff == WORD_LAST);
   end

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      word_in     = word_ff;
      len_in      = len_ff;
      rnd_in      = rnd_ff;
      out_idx_in  = out_idx_ff;
      closing_in  = closing_ff;
      mark_in     = mark_ff;
      len_ok_in   = len_ok_ff;
      final_in    = final_ff;
      hash_in     = hash_ff;
      absorb      = 1'b0;
      absorb_byte = '0;
      sched_ctl   = '0;
      round_ctl   = '0;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_data.has_byte) begin
                  absorb      = 1'b1;
                  absorb_byte = req_data.data_byte;
                  count_in    = count_next;
               end
               if (req_data.end_of_message) begin
                  closing_in = 1'b1;
                  mark_in    = 1'b1;
                  final_in   = 1'b0;
                  len_ok_in  = (pos_after < LEN_POS);
                  len_in     = {(req_data.has_byte ? count_next : count_ff), 3'b000};
               end
               if (req_data.has_byte && (pos_ff == BLOCK_LAST)) begin
                  state_in = ST_ROUND;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            absorb = 1'b1;
            if (mark_ff) begin
               absorb_byte = PAD_MARK;
               mark_in     = 1'b0;
            end else if (len_ok_ff && (pos_ff >= LEN_POS)) begin
               absorb_byte = len_ff[63:56];
               len_in      = {len_ff[55:0], 8'h00};
            end
            if (pos_ff == BLOCK_LAST) begin
               state_in = ST_ROUND;
               if (len_ok_ff) begin
                  final_in = 1'b1;
               end else begin
                  len_ok_in = 1'b1;
               end
            end
         end
         ST_ROUND: begin
            round_ctl.step    = 1'b1;
            sched_ctl.advance = 1'b1;
            rnd_in            = rnd_ff + 6'd1;
            if (rnd_ff == ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + work_words[i];
            end
            if (!closing_ff) begin
               state_in = ST_IDLE;
            end else if (final_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == WORD_LAST) begin
                  state_in   = ST_IDLE;
                  count_in   = '0;
                  closing_in = 1'b0;
                  final_in   = 1'b0;
                  for (int i = 0; i < 8; i++) begin
                     hash_in[i] = iv_word(3'(i));
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (absorb) begin
         word_in = {word_ff[15:0], absorb_byte};
         pos_in  = pos_ff + 6'd1;
         if (pos_ff[1:0] == 2'b11) begin
            sched_ctl.push = 1'b1;
         end
         if (pos_ff == BLOCK_LAST) begin
            round_ctl.load = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         count_ff   <= '0;
         rnd_ff     <= '0;
         out_idx_ff <= '0;
         closing_ff <= 1'b0;
         mark_ff    <= 1'b0;
         len_ok_ff  <= 1'b0;
         final_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= iv_word(3'(i));
         end
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         rnd_ff     <= rnd_in;
         out_idx_ff <= out_idx_in;
         closing_ff <= closing_in;
         mark_ff    <= mark_in;
         len_ok_ff  <= len_ok_in;
         final_ff   <= final_in;
         hash_ff    <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      len_ff  <= len_in;
   end

`ifndef ASSERT_OFF
   a_out_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("digest output while intake open");

   a_round_at_block_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (pos_ff == '0))
      else $error("compression running with partial block fill");

   a_add_after_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> ($past(state_ff) == ST_ROUND && rnd_ff == '0))
      else $error("hash add without full round sequence");

   a_clear_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_word) |=>
         (state_ff == ST_IDLE && count_ff == '0 && !closing_ff))
      else $error("message state not cleared after last digest transfer");
`endif

endmodule

// File: sim/digest_checker.sv
`timescale 1ns / 1ps
// Digest checker: watches both channels, predicts SHA-256 digest words, compares each digest transfer.
module digest_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  smd_pkg::smd_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  smd_pkg::smd_rsp_type rsp_data,
   output int                   error_count,
   output int                   pending_count
);
   import smd_pkg::*;

   localparam logic [0:7][31:0] INIT_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [0:63][31:0] ROUND_CONST = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   logic [60:0] msg_bytes;
   smd_rsp_type digest_due [$];

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic start_message();
      for (int i = 0; i < 8; i++) hash_state[i] = INIT_HASH[i];
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      msg_bytes = '0;
   endtask

   task automatic fold_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_CONST[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] = hash_state[0] + a; hash_state[1] = hash_state[1] + b;
      hash_state[2] = hash_state[2] + c; hash_state[3] = hash_state[3] + d;
      hash_state[4] = hash_state[4] + e; hash_state[5] = hash_state[5] + f;
      hash_state[6] = hash_state[6] + g; hash_state[7] = hash_state[7] + h;
   endtask

   task automatic digest_absorb(input smd_req_type item);
      logic [5:0]  fill;
      logic [63:0] bit_len;
      smd_rsp_type word;
      if (item.has_byte) begin
         fill = msg_bytes[5:0];
         msg_block[fill] = item.data_byte;
         msg_bytes = msg_bytes + 61'd1;
         if (fill == 6'd63) fold_block();
      end
      if (item.end_of_message) begin
         fill = msg_bytes[5:0];
         bit_len = {msg_bytes, 3'b000};
         msg_block[fill] = 8'h80;
         for (int i = 0; i < 64; i++) if (i > fill) msg_block[i] = 8'h00;
         if (fill >= 6'd56) begin
            fold_block();
            for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[8*(7-i) +: 8];
         fold_block();
         for (int i = 0; i < 8; i++) begin
            word.digest_word = hash_state[i];
            word.word_index = 3'(i);
            word.last_word = (i == 7);
            digest_due = {digest_due, word};
         end
         start_message();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("digest_checker: %s mismatch, got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic check_word(input smd_rsp_type got);
      smd_rsp_type want;
      if (digest_due.size() == 0) begin
         report_mismatch("unexpected word", got.digest_word, 32'h0);
         return;
      end
      want = digest_due.pop_front();
      if (got.digest_word !== want.digest_word)
         report_mismatch("digest_word", got.digest_word, want.digest_word);
      if (got.word_index !== want.word_index)
         report_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
      if (got.last_word !== want.last_word)
         report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_message();
         digest_due.delete();
      end else begin
         if (req_valid && !req_stall) digest_absorb(req_data);
         if (rsp_valid && !rsp_stall) check_word(rsp_data);
      end
      pending_count <= digest_due.size();
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, byte-stream stimulus, result-side stalls and the verdict.
module tb_top;
   import smd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 300;
   localparam int RANDOM_ITEMS = 170;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   smd_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   smd_rsp_type rsp_data;

   int error_count;
   int pending_count;
   int cycle_count = 0;
   int items_sent = 0;
   int req_idle_pct = 22;
   int rsp_idle_pct = 63;
   bit hold_request = 1'b0;

   sha256_message_digest u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   digest_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   function automatic smd_req_type make_item(input logic [7:0] value, input logic has,
                                             input logic closing);
      smd_req_type item;
      item.data_byte = value;
      item.has_byte = has;
      item.end_of_message = closing;
      return item;
   endfunction

   task automatic send_item(input smd_req_type item);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      if (item.has_byte || item.end_of_message) items_sent++;
   endtask

   task automatic send_message(input int len, input bit close_on_byte);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 6)
            send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
         send_item(make_item(8'($urandom_range(0, 255)), 1'b1,
                             close_on_byte && (i == len - 1)));
      end
      if (!close_on_byte || len == 0)
         send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      int base;
      int used;
      int msg_index;
      int len;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty message, idle, single bytes at the extremes, short messages
      send_item(make_item(8'h00, 1'b0, 1'b1));
      send_item(make_item(8'h3c, 1'b0, 1'b0));
      send_item(make_item(8'h00, 1'b1, 1'b1));
      send_item(make_item(8'hff, 1'b1, 1'b1));
      send_item(make_item(8'h61, 1'b1, 1'b0));
      send_item(make_item(8'h62, 1'b1, 1'b0));
      send_item(make_item(8'hc3, 1'b0, 1'b0));
      send_item(make_item(8'h63, 1'b1, 1'b1));
      send_item(make_item(8'ha5, 1'b1, 1'b0));
      send_item(make_item(8'h5a, 1'b1, 1'b0));
      send_item(make_item(8'hff, 1'b0, 1'b1));

      base = items_sent;
      msg_index = 0;
      while (items_sent - base < RANDOM_ITEMS || msg_index < 6) begin
         used = items_sent - base;
         if (used < RANDOM_ITEMS / 3) begin
            req_idle_pct = 22;
            rsp_idle_pct = 63;
         end else if (used < 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct = 63;
            rsp_idle_pct = 22;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         case (msg_index % 4)
            0: len = $urandom_range(0, 12);
            1: len = $urandom_range(54, 57);
            2: len = $urandom_range(62, 66);
            default: len = $urandom_range(1, 30);
         endcase
         if (msg_index == 2) drain_results();
         if (msg_index == 3) hold_request = 1'b1;
         send_message(len, 1'($urandom_range(0, 1)));
         msg_index++;
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
